@@ rtl/core/whb_pkg.sv @@
// Shared types and constants of the weighted histogram binner.
// Depends on nothing; every module of the block refers to it by scoped names.
package whb_pkg;

  // Built depth of the bin store and derived widths
  localparam int unsigned MaxBins = 64;
  localparam int unsigned IdxW    = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  // Quotient bits resolved: the index bits plus one overflow bit
  localparam int unsigned QuotW   = IdxW + 1;
  localparam int unsigned CntW    = $clog2(QuotW + 1);

  localparam int unsigned LabelW  = 32;
  localparam int unsigned WeightW = 32;
  localparam int unsigned WidthW  = 31;
  localparam int unsigned CountW  = 7;
  localparam int unsigned TotalW  = 48;
  localparam int unsigned OutIdxW = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;
  // Divisor register width: the bin width plus the quotient bits
  localparam int unsigned DivW    = WidthW + QuotW;
  // Width used to compare the quotient against the bin count
  localparam int unsigned CmpW    = (QuotW > CountW) ? QuotW : CountW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBinCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRangeStart = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBinWidth   = 2'd2;

  localparam logic [CountW-1:0] ResetBinCount = 7'd64;
  localparam logic [WidthW-1:0] ResetBinWidth = 31'd65536;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StUpd
  } whb_state_e;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } whb_div_res_t;

  typedef struct packed {
    logic              sat;
    logic [TotalW-1:0] total;
  } whb_acc_res_t;

endpackage

@@ rtl/core/whb_divider.sv @@
// Serial quotient unit: resolves one quotient bit per cycle, most significant first.
// Depends on whb_pkg.
module whb_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [whb_pkg::LabelW-1:0]          dividend_i,
  input  logic [whb_pkg::WidthW-1:0]          divisor_i,
  output whb_pkg::whb_div_res_t               res_o
);

  logic                         active_q, active_d;
  logic [whb_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [whb_pkg::LabelW-1:0]   rem_q, rem_d;
  logic [whb_pkg::DivW-1:0]     div_q, div_d;
  logic [whb_pkg::QuotW-1:0]    quot_q, quot_d;
  logic [whb_pkg::DivW-1:0]     rem_ext;
  logic [whb_pkg::DivW-1:0]     diff;
  logic                         fits;

  assign rem_ext = {{(whb_pkg::DivW - whb_pkg::LabelW){1'b0}}, rem_q};
  assign fits    = (rem_ext >= div_q);
  assign diff    = rem_ext - div_q;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    div_d    = div_q;
    quot_d   = quot_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = whb_pkg::CntW'(whb_pkg::QuotW);
      rem_d    = dividend_i;
      div_d    = {divisor_i, {whb_pkg::QuotW{1'b0}}} >> 1;
      quot_d   = '0;
    end else if (active_q) begin
      if (cnt_q != '0) begin
        // one restoring step: subtract when the shifted divisor fits
        if (fits) begin
          rem_d = diff[whb_pkg::LabelW-1:0];
        end
        quot_d = {quot_q[whb_pkg::QuotW-2:0], fits};
        div_d  = div_q >> 1;
        cnt_d  = cnt_q - 1'b1;
      end else begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

  assign res_o.done = active_q && (cnt_q == '0);
  assign res_o.quot = quot_q;

endmodule

@@ rtl/core/whb_bin_acc.sv @@
// Bin total store with registered read and saturating accumulate on write-back.
// Depends on whb_pkg.
module whb_bin_acc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [whb_pkg::IdxW-1:0]      rd_addr_i,
  input  logic [whb_pkg::WeightW-1:0]   weight_i,
  input  logic                          wr_en_i,
  output whb_pkg::whb_acc_res_t         acc_o
);

  logic [whb_pkg::TotalW-1:0] mem_q [whb_pkg::MaxBins];
  logic [whb_pkg::MaxBins-1:0] valid_q;
  logic [whb_pkg::TotalW-1:0] rdata_q;
  logic                       rvalid_q;
  logic [whb_pkg::IdxW-1:0]   addr_q;
  logic [whb_pkg::TotalW-1:0] cur_total;
  logic [whb_pkg::TotalW:0]   sum;

  // entries never written read as zero
  assign cur_total = rvalid_q ? rdata_q : '0;
  assign sum = {1'b0, cur_total}
             + {{(whb_pkg::TotalW + 1 - whb_pkg::WeightW){1'b0}}, weight_i};

  assign acc_o.sat   = sum[whb_pkg::TotalW];
  assign acc_o.total = sum[whb_pkg::TotalW] ? {whb_pkg::TotalW{1'b1}}
                                            : sum[whb_pkg::TotalW-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
      addr_q  <= rd_addr_i;
    end
    if (wr_en_i) begin
      mem_q[addr_q] <= acc_o.total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
      if (wr_en_i) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/weighted_histogram_binner_core.sv @@
// Top level of the weighted histogram binner: configuration, control and result register.
// Depends on whb_pkg, whb_divider and whb_bin_acc.
//
// Usage
//   Input channel (in_valid_i/in_ready_o) takes one request: a signed Q16.16
//   label and an unsigned Q16.16 weight. The label picks the equal-width bin
//   floor((label - range_start) / bin_width); the weight is added to that
//   bin's 48-bit total, which clips at all ones and flags saturated.
//   Output channel (out_valid_o/out_ready_i) returns one result per request:
//   in_range, bin_index, the new bin_total and saturated (all zero when the
//   label falls outside the bins in use).
//   Configuration channel (cfg_valid_i/cfg_ready_o) is always ready; index 0
//   bin_count, 1 range_start, 2 bin_width, other indexes are ignored.
// Timing
//   One request at a time. After acceptance the serial divider resolves one
//   quotient bit per cycle (index bits plus one overflow bit), then the bin is
//   read into a register and the write-back step writes it back and loads the
//   result register, which sets out_valid_o. A new request is taken only once
//   the control is back in idle.
// Reset and stall
//   Reset clears all bin totals (per-bin valid flags, no sweep), loads the
//   default registers and empties the result register. A stalled receiver
//   holds the result; the next request is still taken and worked on, and it
//   waits in the write-back step until the result register is free.
module weighted_histogram_binner_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [whb_pkg::LabelW-1:0]    label_i,
  input  logic [whb_pkg::WeightW-1:0]   weight_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          in_range_o,
  output logic [whb_pkg::OutIdxW-1:0]   bin_index_o,
  output logic [whb_pkg::TotalW-1:0]    bin_total_o,
  output logic                          saturated_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [whb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [whb_pkg::CfgDatW-1:0]   cfg_data_i
);

  whb_pkg::whb_state_e state_q, state_d;

  // configuration registers
  logic [whb_pkg::CountW-1:0]  bin_count_q;
  logic [whb_pkg::LabelW-1:0]  range_start_q;
  logic [whb_pkg::WidthW-1:0]  bin_width_q;

  // request context held while the quotient is resolved
  logic [whb_pkg::WeightW-1:0] weight_q;
  logic                        neg_q;
  logic                        hit_q, hit_d;
  logic [whb_pkg::CmpW-1:0]    idx_q, idx_d;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic                        in_range_q;
  logic [whb_pkg::OutIdxW-1:0] bin_index_q;
  logic [whb_pkg::TotalW-1:0]  bin_total_q;
  logic                        saturated_q;

  logic                        in_acc;
  logic                        out_free;
  logic [whb_pkg::LabelW:0]    diff_ext;
  logic [whb_pkg::CmpW-1:0]    used;
  logic [whb_pkg::CmpW-1:0]    quot_ext;
  logic                        div_start;
  logic                        rd_en;
  logic                        wr_en;
  logic                        load_out;
  whb_pkg::whb_div_res_t       div_res;
  whb_pkg::whb_acc_res_t       acc_res;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // label minus start at one extra bit; the top bit marks a label below the start
  assign diff_ext = {label_i[whb_pkg::LabelW-1], label_i}
                  - {range_start_q[whb_pkg::LabelW-1], range_start_q};

  // bins in use, clipped to the built depth
  assign used = ({{(whb_pkg::CmpW - whb_pkg::CountW){1'b0}}, bin_count_q}
                 > whb_pkg::CmpW'(whb_pkg::MaxBins))
              ? whb_pkg::CmpW'(whb_pkg::MaxBins)
              : {{(whb_pkg::CmpW - whb_pkg::CountW){1'b0}}, bin_count_q};

  assign quot_ext = {{(whb_pkg::CmpW - whb_pkg::QuotW){1'b0}}, div_res.quot};

  whb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_ext[whb_pkg::LabelW-1:0]),
    .divisor_i  (bin_width_q),
    .res_o      (div_res)
  );

  whb_bin_acc u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (div_res.quot[whb_pkg::IdxW-1:0]),
    .weight_i  (weight_q),
    .wr_en_i   (wr_en),
    .acc_o     (acc_res)
  );

  // control: accept, divide and read the bin, then write back and load the result
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    div_start   = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    load_out    = 1'b0;
    hit_d       = hit_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      whb_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          div_start = 1'b1;
          state_d   = whb_pkg::StDiv;
        end
      end
      whb_pkg::StDiv: begin
        if (div_res.done) begin
          // a zero width yields an all-ones quotient, so it is caught too
          hit_d   = !neg_q && (bin_width_q != '0) && (quot_ext < used);
          idx_d   = quot_ext;
          rd_en   = hit_d;
          state_d = whb_pkg::StUpd;
        end
      end
      whb_pkg::StUpd: begin
        if (out_free) begin
          wr_en       = hit_q;
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = whb_pkg::StIdle;
        end
      end
      default: begin
        state_d = whb_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= whb_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration writes, taken in any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q   <= whb_pkg::ResetBinCount;
      range_start_q <= '0;
      bin_width_q   <= whb_pkg::ResetBinWidth;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        whb_pkg::CfgBinCount:   bin_count_q   <= cfg_data_i[whb_pkg::CountW-1:0];
        whb_pkg::CfgRangeStart: range_start_q <= cfg_data_i[whb_pkg::LabelW-1:0];
        whb_pkg::CfgBinWidth:   bin_width_q   <= cfg_data_i[whb_pkg::WidthW-1:0];
        default: ;
      endcase
    end
  end

  // request context and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      weight_q <= weight_i;
      neg_q    <= diff_ext[whb_pkg::LabelW];
    end
    hit_q <= hit_d;
    idx_q <= idx_d;
    if (load_out) begin
      in_range_q  <= hit_q;
      bin_index_q <= hit_q ? idx_q[whb_pkg::OutIdxW-1:0] : '0;
      bin_total_q <= hit_q ? acc_res.total : '0;
      saturated_q <= hit_q && acc_res.sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_range_o  = in_range_q;
  assign bin_index_o = bin_index_q;
  assign bin_total_o = bin_total_q;
  assign saturated_o = saturated_q;

endmodule

@@ rtl/core/whb_checker.sv @@
// Port-level checks of the weighted histogram binner, bound to the top level.
// Depends on whb_pkg and weighted_histogram_binner_core.
module whb_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic [whb_pkg::LabelW-1:0]    label_i,
  input  logic [whb_pkg::WeightW-1:0]   weight_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          in_range_o,
  input  logic [whb_pkg::OutIdxW-1:0]   bin_index_o,
  input  logic [whb_pkg::TotalW-1:0]    bin_total_o,
  input  logic                          saturated_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [whb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [whb_pkg::CfgDatW-1:0]   cfg_data_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_total_o))
    else $error("result dropped or changed while stalled");

  // an ignored label reports nothing
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> bin_index_o == '0 && bin_total_o == '0 && !saturated_o)
    else $error("out-of-range result carries data");

  // a clipped total sits at the maximum
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> bin_total_o == {whb_pkg::TotalW{1'b1}})
    else $error("saturated total below maximum");

  // one request in flight: no acceptance in the cycle after one
  a_one_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // configuration is never back-pressured
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind weighted_histogram_binner_core whb_checker u_whb_checker (.*);
